// File: rtl/core/pfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and codes for the port rule packet filter
// Operation codes, result status codes, the search token that travels down
// the rule cell chain and the rule write bus broadcast to every cell.
// ----------------------------------------------------------------------------
package pfr_pkg;

  // Operation codes
  localparam logic [1:0] OP_CLASSIFY = 2'd0;
  localparam logic [1:0] OP_APPEND   = 2'd1;
  localparam logic [1:0] OP_LIST     = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_PASS      = 3'd0;
  localparam logic [2:0] ST_FORWARDED = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_ADDED     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_LISTED    = 3'd5;
  localparam logic [2:0] ST_END       = 3'd6;

  // Forward destination after reset: 100.1.1.10
  localparam logic [31:0] FWD_ADDR_RESET = 32'h6401_010A;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } pfr_state_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic        active;
    logic        list_mode;
    logic        hit;
    logic [15:0] match_port;
    logic [15:0] new_port;
    logic        fwd;
  } pfr_tok_t;

  // Rule write bus
  typedef struct packed {
    logic        en;
    logic [15:0] match_port;
    logic [15:0] new_port;
    logic        fwd;
  } pfr_wr_t;

endpackage : pfr_pkg
`default_nettype wire

// File: rtl/core/pfr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_cell: one rule slot of the filter chain
// Holds one rule and a registered copy of the search token. A token that has
// not hit yet takes this rule when the slot is written and its match port
// equals the packet source port; a list token takes the rule at the cursor.
// ----------------------------------------------------------------------------
module pfr_cell #(
  parameter int SLOTS = 16,
  parameter int IDX   = 0
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire pfr_pkg::pfr_wr_t         wr,
  input  wire [$clog2(SLOTS+1)-1:0]     count,
  input  wire [$clog2(SLOTS+1)-1:0]     list_idx,
  input  wire [15:0]                    key_port,
  input  wire pfr_pkg::pfr_tok_t        tok_in,
  output pfr_pkg::pfr_tok_t             tok_out
);
  import pfr_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [15:0] match_port_r;
  logic [15:0] new_port_r;
  logic        fwd_r;
  pfr_tok_t    tok_r;
  pfr_tok_t    tok_nxt;

  // Store the rule when the append lands on this slot
  always_ff @(posedge clk) begin
    if (wr.en && (count == MY_IDX)) begin
      match_port_r <= wr.match_port;
      new_port_r   <= wr.new_port;
      fwd_r        <= wr.fwd;
    end
  end

  // Claim the token on a first match or on the listed slot
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.active) begin
      if (tok_in.list_mode) begin
        if (list_idx == MY_IDX) begin
          tok_nxt.hit        = 1'b1;
          tok_nxt.match_port = match_port_r;
          tok_nxt.new_port   = new_port_r;
          tok_nxt.fwd        = fwd_r;
        end
      end else if (!tok_in.hit && (MY_IDX < count) && (match_port_r == key_port)) begin
        tok_nxt.hit        = 1'b1;
        tok_nxt.match_port = match_port_r;
        tok_nxt.new_port   = new_port_r;
        tok_nxt.fwd        = fwd_r;
      end
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r.active <= tok_nxt.active;
    end
    tok_r.list_mode  <= tok_nxt.list_mode;
    tok_r.hit        <= tok_nxt.hit;
    tok_r.match_port <= tok_nxt.match_port;
    tok_r.new_port   <= tok_nxt.new_port;
    tok_r.fwd        <= tok_nxt.fwd;
  end

  assign tok_out = tok_r;

endmodule : pfr_cell
`default_nettype wire

// File: rtl/core/port_rule_packet_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// port_rule_packet_filter: first-match port rule filter with port rewrite
// Ordered rule table held in a chain of cells. Classify and list send a token
// down the chain; append writes the next free cell; results are strobed.
// ----------------------------------------------------------------------------
//  channel   ports                                  handshake
//  input     in_opcode, in_pkt_*, in_rule_*         start & !busy
//  result    out_status, out_*                      out_valid, one cycle
//  config    cfg_wdata                              cfg_we
//
//  Classify and list: the token passes one cell per cycle, and the result
//  is registered from the last cell; busy is high while the token is in
//  the chain.
//  Append, list at end of table and unused opcodes: result in the cycle after
//  accept, busy stays low.
//  Synchronous reset clears the rule count and list cursor and loads the reset
//  forward address; rule contents are undefined until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module port_rule_packet_filter #(
  parameter int RULE_SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  // input item
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  in_opcode,
  input  wire  [15:0] in_pkt_src_port,
  input  wire  [15:0] in_pkt_dst_port,
  input  wire  [31:0] in_pkt_dst_addr,
  input  wire  [15:0] in_rule_match_port,
  input  wire  [15:0] in_rule_new_port,
  input  wire         in_rule_forward,
  // result item
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [31:0] out_dst_addr,
  output logic [15:0] out_listed_match_port,
  output logic [15:0] out_listed_new_port,
  output logic        out_listed_forward,
  // configuration
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata
);
  import pfr_pkg::*;

  localparam int CW = $clog2(RULE_SLOTS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(RULE_SLOTS);

  pfr_state_t  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] list_idx_r;
  logic [15:0] src_r, dst_r;
  logic [31:0] addr_r;
  logic [31:0] fwd_addr_r;

  logic        accept;
  logic        list_ok;
  logic        table_full;
  logic        need_search;
  logic [15:0] key_sel;
  logic [CW-1:0] lidx_sel;

  pfr_tok_t    chain [0:RULE_SLOTS];
  pfr_tok_t    head_tok;
  pfr_tok_t    tail_tok;
  pfr_wr_t     wr_bus;

  logic        res_valid;
  logic [2:0]  res_status;
  logic [15:0] res_src, res_dst;
  logic [31:0] res_addr;
  logic [15:0] res_lmatch, res_lnew;
  logic        res_lfwd;

  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [15:0] osrc_r, odst_r;
  logic [31:0] oaddr_r;
  logic [15:0] lmatch_r, lnew_r;
  logic        lfwd_r;

  assign busy        = (state_r == S_SEARCH);
  assign accept      = start && !busy;
  assign list_ok     = (cursor_r < count_r);
  assign table_full  = (count_r == FULL_COUNT);
  assign need_search = (in_opcode == OP_CLASSIFY) || ((in_opcode == OP_LIST) && list_ok);
  assign tail_tok    = chain[RULE_SLOTS];

  // The first cell sees the token in the accept cycle: feed it the live item
  assign key_sel  = accept ? in_pkt_src_port : src_r;
  assign lidx_sel = accept ? cursor_r : list_idx_r;

  // Rule cell chain
  assign chain[0] = head_tok;
  for (genvar k = 0; k < RULE_SLOTS; k++) begin : g_cell
    pfr_cell #(
      .SLOTS (RULE_SLOTS),
      .IDX   (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr       (wr_bus),
      .count    (count_r),
      .list_idx (lidx_sel),
      .key_port (key_sel),
      .tok_in   (chain[k]),
      .tok_out  (chain[k+1])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && need_search) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (tail_tok.active) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Launch token and rule write bus
  always_comb begin
    head_tok            = '0;
    head_tok.active     = accept && need_search;
    head_tok.list_mode  = (in_opcode == OP_LIST);
    wr_bus.en           = accept && (in_opcode == OP_APPEND) && !table_full;
    wr_bus.match_port   = in_rule_match_port;
    wr_bus.new_port     = in_rule_new_port;
    wr_bus.fwd          = in_rule_forward;
  end

  // Count and cursor updates
  always_comb begin
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    if (accept) begin
      case (in_opcode)
        OP_APPEND: begin
          if (!table_full) begin
            count_nxt = count_r + CW'(1);
          end
        end
        OP_LIST: begin
          if (list_ok) begin
            cursor_nxt = cursor_r + CW'(1);
          end else begin
            cursor_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result composition
  always_comb begin
    res_valid  = 1'b0;
    res_status = ST_PASS;
    res_src    = '0;
    res_dst    = '0;
    res_addr   = '0;
    res_lmatch = '0;
    res_lnew   = '0;
    res_lfwd   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_CLASSIFY: ;
            OP_APPEND: begin
              res_valid  = 1'b1;
              res_status = table_full ? ST_FULL : ST_ADDED;
            end
            OP_LIST: begin
              if (!list_ok) begin
                res_valid  = 1'b1;
                res_status = ST_END;
              end
            end
            default: begin
              res_valid  = 1'b1;
              res_status = ST_PASS;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (tail_tok.active) begin
          res_valid = 1'b1;
          if (tail_tok.list_mode) begin
            res_status = ST_LISTED;
            res_lmatch = tail_tok.match_port;
            res_lnew   = tail_tok.new_port;
            res_lfwd   = tail_tok.fwd;
          end else if (tail_tok.hit) begin
            res_src    = tail_tok.new_port;
            res_dst    = tail_tok.new_port;
            res_addr   = tail_tok.fwd ? fwd_addr_r : addr_r;
            res_status = tail_tok.fwd ? ST_FORWARDED : ST_DROPPED;
          end else begin
            res_status = ST_PASS;
            res_src    = src_r;
            res_dst    = dst_r;
            res_addr   = addr_r;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      fwd_addr_r  <= FWD_ADDR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= res_valid;
      if (cfg_we) begin
        fwd_addr_r <= cfg_wdata;
      end
    end
  end

  // Hold the header and list slot of the item being searched
  always_ff @(posedge clk) begin
    if (accept) begin
      src_r      <= in_pkt_src_port;
      dst_r      <= in_pkt_dst_port;
      addr_r     <= in_pkt_dst_addr;
      list_idx_r <= cursor_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    status_r <= res_status;
    osrc_r   <= res_src;
    odst_r   <= res_dst;
    oaddr_r  <= res_addr;
    lmatch_r <= res_lmatch;
    lnew_r   <= res_lnew;
    lfwd_r   <= res_lfwd;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_src_port          = osrc_r;
  assign out_dst_port          = odst_r;
  assign out_dst_addr          = oaddr_r;
  assign out_listed_match_port = lmatch_r;
  assign out_listed_new_port   = lnew_r;
  assign out_listed_forward    = lfwd_r;

endmodule : port_rule_packet_filter
`default_nettype wire

// File: tb/port_rule_packet_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// port_rule_packet_filter_checker: result predictor and scoreboard
// Watches the input, result and configuration ports of the packet filter,
// keeps its own copy of the rule table, list cursor and forward address,
// predicts one result per accepted item and compares every result strobe
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module port_rule_packet_filter_checker #(
  parameter int RULE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_pkt_src_port,
  input  logic [15:0] in_pkt_dst_port,
  input  logic [31:0] in_pkt_dst_addr,
  input  logic [15:0] in_rule_match_port,
  input  logic [15:0] in_rule_new_port,
  input  logic        in_rule_forward,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_src_port,
  input  logic [15:0] out_dst_port,
  input  logic [31:0] out_dst_addr,
  input  logic [15:0] out_listed_match_port,
  input  logic [15:0] out_listed_new_port,
  input  logic        out_listed_forward,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          open_items
);
  import pfr_pkg::*;

  typedef struct packed {
    logic [15:0] match_port;
    logic [15:0] new_port;
    logic        fwd;
  } port_rule_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] src_out;
    logic [15:0] dst_out;
    logic [31:0] addr_out;
    logic [15:0] listed_match_port;
    logic [15:0] listed_new_port;
    logic        listed_forward;
  } filter_result_t;

  port_rule_t     rule_table [RULE_SLOTS];
  int unsigned    rule_count;
  int unsigned    list_pos;
  logic [31:0]    fwd_addr;
  filter_result_t expected_q [$];
  int             mismatch_cnt = 0;
  int             waiting_cnt  = 0;

  assign fail_count = mismatch_cnt;
  assign open_items = waiting_cnt;

  // Apply one item to the rule table and return the result it produces
  function automatic filter_result_t filter_item(logic [1:0] op, logic [15:0] src,
                                                 logic [15:0] dst, logic [31:0] addr,
                                                 port_rule_t rule_in);
    filter_result_t res;
    bit             hit;
    res = '0;
    hit = 1'b0;
    case (op)
      OP_CLASSIFY: begin
        res.status   = ST_PASS;
        res.src_out  = src;
        res.dst_out  = dst;
        res.addr_out = addr;
        // first rule with an equal source port wins
        for (int unsigned i = 0; i < rule_count; i++) begin
          if (!hit && rule_table[i].match_port == src) begin
            hit         = 1'b1;
            res.src_out = rule_table[i].new_port;
            res.dst_out = rule_table[i].new_port;
            if (rule_table[i].fwd) begin
              res.addr_out = fwd_addr;
              res.status   = ST_FORWARDED;
            end else begin
              res.status = ST_DROPPED;
            end
          end
        end
      end
      OP_APPEND: begin
        if (rule_count < RULE_SLOTS) begin
          rule_table[rule_count] = rule_in;
          rule_count++;
          res.status = ST_ADDED;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_LIST: begin
        // walk one rule per call, then the end mark, then start over
        if (list_pos < rule_count) begin
          res.status            = ST_LISTED;
          res.listed_match_port = rule_table[list_pos].match_port;
          res.listed_new_port   = rule_table[list_pos].new_port;
          res.listed_forward    = rule_table[list_pos].fwd;
          list_pos++;
        end else begin
          res.status = ST_END;
          list_pos   = 0;
        end
      end
      default: begin
        res.status = ST_PASS;
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%h, got 0x%h", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Compare results first: a result at this edge belongs to an earlier item
  always @(posedge clk) begin
    filter_result_t want;
    port_rule_t     rule_in;
    if (!rst_n) begin
      rule_count = 0;
      list_pos   = 0;
      fwd_addr   = FWD_ADDR_RESET;
      expected_q.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d",
                   $time, out_status);
          mismatch_cnt++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("out_src_port", 32'(want.src_out), 32'(out_src_port));
          check_field("out_dst_port", 32'(want.dst_out), 32'(out_dst_port));
          check_field("out_dst_addr", want.addr_out, out_dst_addr);
          check_field("listed_match_port", 32'(want.listed_match_port),
                      32'(out_listed_match_port));
          check_field("listed_new_port", 32'(want.listed_new_port),
                      32'(out_listed_new_port));
          check_field("listed_forward", 32'(want.listed_forward),
                      32'(out_listed_forward));
        end
      end
      if (start && !busy) begin
        rule_in = '{in_rule_match_port, in_rule_new_port, in_rule_forward};
        expected_q.push_back(filter_item(in_opcode, in_pkt_src_port, in_pkt_dst_port,
                                         in_pkt_dst_addr, rule_in));
      end
      if (cfg_we) begin
        fwd_addr = cfg_wdata;
      end
    end
    waiting_cnt = expected_q.size();
  end

endmodule

// File: tb/port_rule_packet_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// port_rule_packet_filter_tb: stimulus and verdict for the packet filter
// Runs a directed sequence over empty-table, first-match, list wrap and
// append-while-listing cases, then random phases under several forward
// addresses, most with random idle gaps. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module port_rule_packet_filter_tb;
  import pfr_pkg::*;

  localparam int         SLOTS     = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [15:0] in_pkt_src_port;
  logic [15:0] in_pkt_dst_port;
  logic [31:0] in_pkt_dst_addr;
  logic [15:0] in_rule_match_port;
  logic [15:0] in_rule_new_port;
  logic        in_rule_forward;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_src_port;
  logic [15:0] out_dst_port;
  logic [31:0] out_dst_addr;
  logic [15:0] out_listed_match_port;
  logic [15:0] out_listed_new_port;
  logic        out_listed_forward;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          open_items;

  // Match ports sent so far, reused so classify items hit rules
  logic [15:0] sent_ports [$];

  always #5 clk = ~clk;

  port_rule_packet_filter #(
    .RULE_SLOTS (SLOTS)
  ) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_opcode             (in_opcode),
    .in_pkt_src_port       (in_pkt_src_port),
    .in_pkt_dst_port       (in_pkt_dst_port),
    .in_pkt_dst_addr       (in_pkt_dst_addr),
    .in_rule_match_port    (in_rule_match_port),
    .in_rule_new_port      (in_rule_new_port),
    .in_rule_forward       (in_rule_forward),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_src_port          (out_src_port),
    .out_dst_port          (out_dst_port),
    .out_dst_addr          (out_dst_addr),
    .out_listed_match_port (out_listed_match_port),
    .out_listed_new_port   (out_listed_new_port),
    .out_listed_forward    (out_listed_forward),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata)
  );

  port_rule_packet_filter_checker #(
    .RULE_SLOTS (SLOTS)
  ) u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_opcode             (in_opcode),
    .in_pkt_src_port       (in_pkt_src_port),
    .in_pkt_dst_port       (in_pkt_dst_port),
    .in_pkt_dst_addr       (in_pkt_dst_addr),
    .in_rule_match_port    (in_rule_match_port),
    .in_rule_new_port      (in_rule_new_port),
    .in_rule_forward       (in_rule_forward),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_src_port          (out_src_port),
    .out_dst_port          (out_dst_port),
    .out_dst_addr          (out_dst_addr),
    .out_listed_match_port (out_listed_match_port),
    .out_listed_new_port   (out_listed_new_port),
    .out_listed_forward    (out_listed_forward),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .fail_count            (fail_count),
    .open_items            (open_items)
  );

  // Mostly back-to-back, sometimes a short gap, rarely a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold one item until the filter takes it, then idle for the given gap
  task automatic issue_item(logic [1:0] op, logic [15:0] src, logic [15:0] dst,
                            logic [31:0] addr, logic [15:0] rmatch, logic [15:0] rnew,
                            logic rfwd, int unsigned gap);
    start              = 1'b1;
    in_opcode          = op;
    in_pkt_src_port    = src;
    in_pkt_dst_port    = dst;
    in_pkt_dst_addr    = addr;
    in_rule_match_port = rmatch;
    in_rule_new_port   = rnew;
    in_rule_forward    = rfwd;
    if (op == OP_APPEND) sent_ports.push_back(rmatch);
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random item: appends grow the table slowly, classify mostly hits rules
  task automatic issue_random(int unsigned append_pct, bit gaps_on);
    int unsigned r;
    logic [1:0]  op;
    logic [15:0] src;
    logic [15:0] rmatch;
    r = $urandom_range(0, 99);
    if (r < append_pct) op = OP_APPEND;
    else if (r < append_pct + 20) op = OP_LIST;
    else if (r < append_pct + 24) op = OP_UNUSED;
    else op = OP_CLASSIFY;
    src = 16'($urandom);
    if (sent_ports.size() != 0 && $urandom_range(0, 9) < 7) begin
      src = sent_ports[$urandom_range(0, sent_ports.size() - 1)];
    end
    case ($urandom_range(0, 9))
      0: rmatch = 16'h0000;
      1: rmatch = 16'hFFFF;
      2, 3, 4: begin
        rmatch = (sent_ports.size() != 0) ?
                 sent_ports[$urandom_range(0, sent_ports.size() - 1)] : 16'($urandom);
      end
      default: rmatch = 16'($urandom);
    endcase
    issue_item(op, src, 16'($urandom), $urandom, rmatch, 16'($urandom),
               1'($urandom_range(0, 1)), gaps_on ? pick_gap() : 0);
  endtask

  task automatic write_fwd_addr(logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    logic [31:0] cfg_values [4];
    rst_n              = 1'b0;
    start              = 1'b0;
    in_opcode          = OP_CLASSIFY;
    in_pkt_src_port    = '0;
    in_pkt_dst_port    = '0;
    in_pkt_dst_addr    = '0;
    in_rule_match_port = '0;
    in_rule_new_port   = '0;
    in_rule_forward    = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    cfg_values         = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, FWD_ADDR_RESET};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty table: list ends at once, classify passes, unused opcode is inert
    issue_item(OP_LIST, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 1'b0, pick_gap());
    issue_item(OP_CLASSIFY, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0,
               pick_gap());
    issue_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
               pick_gap());
    // Extreme ports, both actions, and a shadowed duplicate match port
    issue_item(OP_APPEND, 16'h0, 16'h0, 32'h0, 16'h0000, 16'hFFFF, 1'b1, pick_gap());
    issue_item(OP_APPEND, 16'h0, 16'h0, 32'h0, 16'hFFFF, 16'h0000, 1'b0, pick_gap());
    issue_item(OP_APPEND, 16'h0, 16'h0, 32'h0, 16'h1234, 16'h4321, 1'b1, pick_gap());
    issue_item(OP_APPEND, 16'h0, 16'h0, 32'h0, 16'h1234, 16'hAAAA, 1'b0, pick_gap());
    // Forward, drop, first match and miss
    issue_item(OP_CLASSIFY, 16'h0000, 16'hFFFF, 32'h0000_0000, 16'h0, 16'h0, 1'b0,
               pick_gap());
    issue_item(OP_CLASSIFY, 16'hFFFF, 16'h8001, 32'hC0A8_0001, 16'h0, 16'h0, 1'b0,
               pick_gap());
    issue_item(OP_CLASSIFY, 16'h1234, 16'h0050, 32'h0A00_0001, 16'h0, 16'h0, 1'b0,
               pick_gap());
    issue_item(OP_CLASSIFY, 16'h5555, 16'h7FFF, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0,
               pick_gap());
    // Start listing, append behind the cursor, list to the end and wrap
    issue_item(OP_LIST, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 1'b0, pick_gap());
    issue_item(OP_LIST, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 1'b0, pick_gap());
    issue_item(OP_APPEND, 16'h0, 16'h0, 32'h0, 16'h8000, 16'h7FFF, 1'b1, pick_gap());
    repeat (4) issue_item(OP_LIST, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 1'b0, pick_gap());
    issue_item(OP_LIST, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 1'b0, pick_gap());
    issue_item(OP_CLASSIFY, 16'h8000, 16'h0001, 32'h0102_0304, 16'h0, 16'h0, 1'b0,
               pick_gap());
    issue_item(OP_UNUSED, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 1'b0, pick_gap());

    // Random phases, each under its own forward address; the table fills
    // up along the way so later appends see the full status
    for (int p = 0; p < 4; p++) begin
      start = 1'b0;
      while (open_items != 0) @(negedge clk);
      write_fwd_addr(cfg_values[p]);
      repeat (233) issue_random(4 + 4 * p, p != 1);
    end
    start = 1'b0;

    // Drain, then give late or extra results time to show up
    while (open_items != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
